// File: design/mpld_pkg.sv
package mpld_pkg;

  localparam int DRIVE_W = 40;
  localparam int COUNT_W = 32;
  localparam int MASK_W  = 8;
  localparam int CH_W    = 6;
  localparam int ADD_W   = 16;
  localparam int LAMP_W  = 32;

  localparam logic [CH_W-1:0]    LAMP_LO     = 6'd8;
  localparam logic [CH_W-1:0]    LAMP_HI     = 6'd39;
  localparam logic [DRIVE_W-1:0] DRIVE_RESET = 40'h30FF;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_LAMP  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              busy;
    logic              release_phase;
    logic [MASK_W-1:0] pulse_mask;
    logic              drive_write;
    logic [DRIVE_W-1:0] drive_word;
  } result_t;

endpackage

// File: design/mpld_step.sv
module mpld_step
  import mpld_pkg::*;
#(
  parameter int NUM_METERS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  logic             meters_enable,
  input  cmd_t             command,
  input  logic [CH_W-1:0]  channel,
  input  logic [ADD_W-1:0] pulse_count,
  output result_t          result
);

  logic [COUNT_W-1:0] counts      [NUM_METERS];
  logic [COUNT_W-1:0] counts_next [NUM_METERS];
  logic [DRIVE_W-1:0] drive_reg, drive_reg_next;
  logic [LAMP_W-1:0]  lamp_pending, lamp_pending_next;
  logic [MASK_W-1:0]  last_mask, last_mask_next;
  logic               turn_flag, turn_flag_next;

  always_comb begin
    logic [COUNT_W:0]   sum;
    logic [MASK_W-1:0]  m;
    logic [DRIVE_W-1:0] grp;
    logic [DRIVE_W-1:0] lamp_bit;
    logic               write;
    logic               busy;
    counts_next       = counts;
    drive_reg_next    = drive_reg;
    lamp_pending_next = lamp_pending;
    last_mask_next    = last_mask;
    turn_flag_next    = turn_flag;
    sum               = '0;
    m                 = '0;
    write             = 1'b0;
    grp               = {lamp_pending, {(DRIVE_W-LAMP_W){1'b0}}};
    lamp_bit          = DRIVE_W'(1) << channel;
    unique case (command)
      CMD_ADD: begin
        for (int i = 0; i < NUM_METERS; i++) begin
          sum = {1'b0, counts[i]} + (COUNT_W+1)'(pulse_count);
          if (channel == CH_W'(i)) begin
            counts_next[i] = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
          end
        end
      end
      CMD_LAMP: begin
        if (channel >= LAMP_LO && channel <= LAMP_HI) begin
          lamp_pending_next = lamp_pending | lamp_bit[DRIVE_W-1:DRIVE_W-LAMP_W];
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NUM_METERS; i++) begin
          counts_next[i] = '0;
        end
        last_mask_next = '0;
        turn_flag_next = 1'b0;
      end
      CMD_TICK: begin
        if (lamp_pending != '0) begin
          // toggle the pending group as a whole
          if ((drive_reg & grp) == '0) begin
            drive_reg_next = drive_reg | grp;
          end else begin
            drive_reg_next = drive_reg & ~grp;
          end
          lamp_pending_next = '0;
          write = 1'b1;
        end
        if (meters_enable) begin
          if (turn_flag) begin
            drive_reg_next = drive_reg_next | DRIVE_W'(last_mask);
            write          = 1'b1;
            last_mask_next = '0;
            turn_flag_next = 1'b0;
          end else begin
            for (int i = 0; i < NUM_METERS; i++) begin
              if (counts[i] != '0) begin
                counts_next[i] = counts[i] - 1'b1;
                m[i]           = 1'b1;
              end
            end
            if (m != '0) begin
              drive_reg_next = drive_reg_next & ~DRIVE_W'(m);
              write          = 1'b1;
              last_mask_next = m;
              turn_flag_next = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    busy = 1'b0;
    for (int i = 0; i < NUM_METERS; i++) begin
      if (counts_next[i] != '0) busy = 1'b1;
    end
    result.drive_word    = drive_reg_next;
    result.drive_write   = write;
    result.pulse_mask    = last_mask_next;
    result.release_phase = turn_flag_next;
    result.busy          = busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_METERS; i++) begin
        counts[i] <= '0;
      end
      drive_reg    <= DRIVE_RESET;
      lamp_pending <= '0;
      last_mask    <= '0;
      turn_flag    <= 1'b0;
    end else if (step_en) begin
      counts       <= counts_next;
      drive_reg    <= drive_reg_next;
      lamp_pending <= lamp_pending_next;
      last_mask    <= last_mask_next;
      turn_flag    <= turn_flag_next;
    end
  end

endmodule

// File: design/meter_pulse_and_lamp_driver_core.sv
// Meter pulse and lamp driver. Drives up to eight electromechanical meter
// coils (drive bits 0..7, active low) and 32 lamps (bits 8..39) through one
// 40-bit drive word. Command words: tick (0) toggles the pending lamp group
// and, with meters_enable set, alternates between a pulse phase (every meter
// with a nonzero counter is decremented and driven low) and a release phase
// (the last pulsed meters go high again); add (1) adds pulse_count to one
// meter counter, saturating at 32 bits; lamp (2) marks lamp bit channel
// (8..39) pending; clear (3) zeroes counters and the phase at once without
// touching the drive word. Every input word yields exactly one result word.
// Throughput is one word per clock while m_axis_tready stays high: an
// accepted word sits in the input register, the step logic computes the
// state update and result from it in the next cycle, and the result lands in
// the output register, which drives m_axis_tvalid. The output register
// decouples the sides: a new input word is taken while a result still waits
// for the sink, as long as the input register is empty. meters_enable is
// written via cfg_valid/cfg_data (always ready); write it only while no
// words are in flight.
module meter_pulse_and_lamp_driver_core
  import mpld_pkg::*;
#(
  parameter int NUM_METERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // channel[5:0], pulse_count[21:6], zero[23:22]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // drive_word[39:0], drive_write[40],
                                     // pulse_mask[48:41], release_phase[49],
                                     // meters_busy[50], zero[55:51]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data       // meters_enable
);

  // input register
  logic             in_valid;
  cmd_t             in_cmd;
  logic [CH_W-1:0]  in_ch;
  logic [ADD_W-1:0] in_cnt;

  // output register
  logic    out_valid;
  result_t out_res;
  result_t step_res;

  logic meters_enable;
  logic advance;

  // the item in the input register moves on when the output slot is free
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      meters_enable <= 1'b0;
    end else if (cfg_valid) begin
      meters_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd <= cmd_t'(s_axis_tuser);
      in_ch  <= s_axis_tdata[CH_W-1:0];
      in_cnt <= s_axis_tdata[CH_W+ADD_W-1:CH_W];
    end
  end

  mpld_step #(
    .NUM_METERS(NUM_METERS)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .step_en      (advance),
    .meters_enable(meters_enable),
    .command      (in_cmd),
    .channel      (in_ch),
    .pulse_count  (in_cnt),
    .result       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_res.busy, out_res.release_phase, out_res.pulse_mask,
                          out_res.drive_write, out_res.drive_word};

endmodule
